// ----- rtl/smbus_master_transaction_sequencer_defines.svh -----
// Assertion macros used by the checker file of the SMBus sequencer.
// Each macro expects clk and rst_n in scope.
`ifndef SMBUS_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define SMBUS_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// Same-cycle implication: when pre holds, post must hold on the same edge.
`define SMS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication: when pre holds, post must hold on the next edge.
`define SMS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/smbus_seq_pkg.sv -----
package smbus_seq_pkg;

  // Longest block transfer, in data bytes.
  localparam int MAX_BLOCK = 32;
  localparam int LEN_W     = 6;
  localparam int TICK_W    = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd12;

  // Results one request can cause.
  localparam int NRES = 3;

  // Transfer kinds as they arrive on the request.
  localparam logic [2:0] KIND_QUICK = 3'd0;
  localparam logic [2:0] KIND_BYTE  = 3'd1;
  localparam logic [2:0] KIND_BDATA = 3'd2;
  localparam logic [2:0] KIND_WORD  = 3'd3;
  localparam logic [2:0] KIND_BLOCK = 3'd4;
  localparam logic [2:0] KIND_I2C   = 3'd5;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_WDATA = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CMD   = 3'd2,
    PH_CNT   = 3'd3,
    PH_NEED  = 3'd4,
    PH_WDATA = 3'd5,
    PH_RADDR = 3'd6,
    PH_RDATA = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ACT_START   = 4'd0,
    ACT_RESTART = 4'd1,
    ACT_WRITE   = 4'd2,
    ACT_RDACK   = 4'd3,
    ACT_RDNACK  = 4'd4,
    ACT_STOP    = 4'd5,
    ACT_DONE    = 4'd6,
    ACT_RDATA   = 4'd7,
    ACT_NEED    = 4'd8
  } act_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_UNFINISHED = 3'd2,
    ST_ARB        = 3'd3,
    ST_NOACK      = 3'd4,
    ST_UNSUP      = 3'd5
  } status_t;

  // One request as held in the input register.
  typedef struct packed {
    req_t            req;
    logic [6:0]      dev_addr;
    logic            read_not_write;
    logic [2:0]      kind;
    logic [7:0]      command;
    logic [LEN_W-1:0] length;
    logic [7:0]      data_byte;
    logic            complete;
    logic            arb_lost;
    logic            nack;
  } item_t;

  // One result.
  typedef struct packed {
    act_t       action;
    logic [7:0] bus_byte;
    status_t    status;
  } res_t;

  // All results of one request, lane 0 first.
  typedef struct packed {
    res_t [NRES-1:0] res;
    logic [1:0]      cnt;
  } bundle_t;

  function automatic res_t mk_res(act_t a, logic [7:0] b, status_t s);
    res_t r;
    r.action   = a;
    r.bus_byte = b;
    r.status   = s;
    return r;
  endfunction

  // Clamp a byte count to the longest block.
  function automatic logic [LEN_W-1:0] sat_len(logic [7:0] v);
    logic [LEN_W-1:0] r;
    if (v > 8'(MAX_BLOCK)) begin
      r = LEN_W'(MAX_BLOCK);
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/smbus_seq_in_reg.sv -----
module smbus_seq_in_reg
  import smbus_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  in_fire;

  // The register frees up whenever the core takes its request.
  assign in_tready  = !valid_r || take;
  assign in_fire    = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Unpack the request fields.
  always_comb begin
    item_nxt.req            = req_t'(in_tuser);
    item_nxt.dev_addr       = in_tdata[6:0];
    item_nxt.read_not_write = in_tdata[7];
    item_nxt.kind           = in_tdata[10:8];
    item_nxt.command        = in_tdata[18:11];
    item_nxt.length         = in_tdata[24:19];
    item_nxt.data_byte      = in_tdata[32:25];
    item_nxt.complete       = in_tdata[33];
    item_nxt.arb_lost       = in_tdata[34];
    item_nxt.nack           = in_tdata[35];
  end

  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/smbus_seq_core.sv -----
module smbus_seq_core
  import smbus_seq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data,
  input  logic              item_valid,
  input  item_t             item,
  input  logic              room,
  output logic              take,
  output logic              push,
  output bundle_t           bnd
);

  phase_t            phase_r, phase_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic              is_read_r, is_read_nxt;
  logic [6:0]        addr_r, addr_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              first_r, first_nxt;
  logic [TICK_W-1:0] wait_r, wait_nxt;
  logic [TICK_W-1:0] timeout_r;

  bundle_t           bnd_c;
  logic [1:0]        n;
  logic              do_rd;
  logic              do_wr;
  logic              do_fin;
  logic              fin_stop;
  status_t           fin_st;
  logic              rbit;
  logic              busy;

  // A request is processed once the result queue can hold all its results.
  assign take = item_valid && room;
  assign push = take && (bnd_c.cnt != 2'd0);
  assign bnd  = bnd_c;
  assign busy = (phase_r != PH_IDLE) && (phase_r != PH_NEED);
  assign rbit = item.read_not_write && (item.kind <= KIND_BYTE);

  // Next state and results for the held request.
  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    is_read_nxt = is_read_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    left_nxt    = left_r;
    first_nxt   = first_r;
    wait_nxt    = wait_r;
    bnd_c       = '0;
    n           = 2'd0;
    do_rd       = 1'b0;
    do_wr       = 1'b0;
    do_fin      = 1'b0;
    fin_stop    = 1'b0;
    fin_st      = ST_OK;

    case (item.req)
      REQ_START: begin
        if (phase_r == PH_IDLE) begin
          if (item.kind > KIND_I2C) begin
            bnd_c.res[n] = mk_res(ACT_DONE, 8'd0, ST_UNSUP);
            n = n + 2'd1;
          end else begin
            kind_nxt    = item.kind;
            is_read_nxt = item.read_not_write;
            addr_nxt    = item.dev_addr;
            cmd_nxt     = item.command;
            first_nxt   = 1'b0;
            case (item.kind)
              KIND_BYTE:  left_nxt = item.read_not_write ? LEN_W'(1) : LEN_W'(0);
              KIND_BDATA: left_nxt = LEN_W'(1);
              KIND_WORD:  left_nxt = LEN_W'(2);
              KIND_BLOCK: begin
                if (item.read_not_write) begin
                  left_nxt  = '0;
                  first_nxt = 1'b1;
                end else begin
                  left_nxt = sat_len({2'b00, item.length});
                end
              end
              KIND_I2C:   left_nxt = sat_len({2'b00, item.length});
              default:    left_nxt = '0;
            endcase
            bnd_c.res[n] = mk_res(ACT_START, {item.dev_addr, rbit}, ST_OK);
            n = n + 2'd1;
            phase_nxt = PH_ADDR;
            wait_nxt  = '0;
          end
        end
      end

      REQ_EVENT: begin
        if (busy) begin
          if (!item.complete) begin
            do_fin   = 1'b1;
            fin_stop = 1'b1;
            fin_st   = ST_UNFINISHED;
          end else if (item.arb_lost) begin
            do_fin = 1'b1;
            fin_st = ST_ARB;
          end else if ((phase_r != PH_RDATA) && item.nack) begin
            do_fin   = 1'b1;
            fin_stop = 1'b1;
            fin_st   = ST_NOACK;
          end else begin
            case (phase_r)
              PH_ADDR: begin
                if (is_read_r && (kind_r <= KIND_BYTE)) begin
                  do_rd = 1'b1;
                end else if (kind_r == KIND_QUICK) begin
                  do_fin   = 1'b1;
                  fin_stop = 1'b1;
                end else begin
                  bnd_c.res[n] = mk_res(ACT_WRITE, cmd_r, ST_OK);
                  n = n + 2'd1;
                  phase_nxt = PH_CMD;
                  wait_nxt  = '0;
                end
              end
              PH_CMD: begin
                if (is_read_r) begin
                  bnd_c.res[n] = mk_res(ACT_RESTART, {addr_r, 1'b1}, ST_OK);
                  n = n + 2'd1;
                  phase_nxt = PH_RADDR;
                  wait_nxt  = '0;
                end else if (kind_r == KIND_BLOCK) begin
                  bnd_c.res[n] = mk_res(ACT_WRITE, 8'(left_r), ST_OK);
                  n = n + 2'd1;
                  phase_nxt = PH_CNT;
                  wait_nxt  = '0;
                end else begin
                  do_wr = 1'b1;
                end
              end
              PH_CNT, PH_WDATA: do_wr = 1'b1;
              PH_RADDR:         do_rd = 1'b1;
              PH_RDATA: begin
                bnd_c.res[n] = mk_res(ACT_RDATA, item.data_byte, ST_OK);
                n = n + 2'd1;
                if (first_r) begin
                  first_nxt = 1'b0;
                  left_nxt  = sat_len(item.data_byte);
                end else if (left_r != '0) begin
                  left_nxt = left_r - LEN_W'(1);
                end
                do_rd = 1'b1;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end

      REQ_WDATA: begin
        if (phase_r == PH_NEED) begin
          bnd_c.res[n] = mk_res(ACT_WRITE, item.data_byte, ST_OK);
          n = n + 2'd1;
          if (left_r != '0) begin
            left_nxt = left_r - LEN_W'(1);
          end
          phase_nxt = PH_WDATA;
          wait_nxt  = '0;
        end
      end

      REQ_TICK: begin
        if (busy) begin
          if (wait_r >= timeout_r) begin
            do_fin   = 1'b1;
            fin_stop = 1'b1;
            fin_st   = ST_TIMEOUT;
          end else begin
            wait_nxt = wait_r + TICK_W'(1);
          end
        end
      end

      default: begin
      end
    endcase

    // Ask the host for the next write byte, or close the transfer.
    if (do_wr) begin
      if (left_nxt != '0) begin
        bnd_c.res[n] = mk_res(ACT_NEED, 8'd0, ST_OK);
        n = n + 2'd1;
        phase_nxt = PH_NEED;
        wait_nxt  = '0;
      end else begin
        do_fin   = 1'b1;
        fin_stop = 1'b1;
      end
    end

    // Start the next read byte; the last one is nacked.
    if (do_rd) begin
      if (first_nxt) begin
        bnd_c.res[n] = mk_res(ACT_RDACK, 8'd0, ST_OK);
        n = n + 2'd1;
        phase_nxt = PH_RDATA;
        wait_nxt  = '0;
      end else if (left_nxt == '0) begin
        do_fin   = 1'b1;
        fin_stop = 1'b1;
      end else begin
        bnd_c.res[n] = mk_res((left_nxt > LEN_W'(1)) ? ACT_RDACK : ACT_RDNACK,
                              8'd0, ST_OK);
        n = n + 2'd1;
        phase_nxt = PH_RDATA;
        wait_nxt  = '0;
      end
    end

    // End of transfer: optional stop, then done with its status.
    if (do_fin) begin
      if (fin_stop) begin
        bnd_c.res[n] = mk_res(ACT_STOP, 8'd0, ST_OK);
        n = n + 2'd1;
      end
      bnd_c.res[n] = mk_res(ACT_DONE, 8'd0, fin_st);
      n = n + 2'd1;
      phase_nxt = PH_IDLE;
      wait_nxt  = '0;
    end

    bnd_c.cnt = n;
  end

  // Transaction state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      kind_r    <= '0;
      is_read_r <= 1'b0;
      addr_r    <= '0;
      cmd_r     <= '0;
      left_r    <= '0;
      first_r   <= 1'b0;
      wait_r    <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      is_read_r <= is_read_nxt;
      addr_r    <= addr_nxt;
      cmd_r     <= cmd_nxt;
      left_r    <= left_nxt;
      first_r   <= first_nxt;
      wait_r    <= wait_nxt;
    end
  end

  // Timeout limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

endmodule

// ----- rtl/smbus_seq_out_q.sv -----
module smbus_seq_out_q
  import smbus_seq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bnd,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res,
  output logic    out_last
);

  bundle_t    slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;
  bundle_t    head;
  logic       pop;
  logic       pop_bnd;

  // Head bundle drains one result per accepted output request.
  assign head      = slot_r[rd_ptr_r];
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = head.res[idx_r];
  assign out_last  = (idx_r == (head.cnt - 2'd1));
  assign pop       = out_valid && out_ready;
  assign pop_bnd   = pop && out_last;
  assign room      = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop_bnd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop_bnd) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue pointers and the lane index within the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_bnd) begin
        rd_ptr_r <= !rd_ptr_r;
        idx_r    <= 2'd0;
      end else if (pop) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bnd;
    end
  end

endmodule

// ----- rtl/smbus_master_transaction_sequencer.sv -----
// Channel   Direction  tdata (low bit first)                       tuser     tlast
// in_*      input      dev_addr, read_not_write, kind, command,    req_type  -
//                      length, data_byte, complete, arb_lost, nack
// out_*     output     bus_byte, status                            action    last
// cfg_*     input      timeout_ticks (write only)                  -         -
//
// A request is accepted every cycle while the result queue has room; it is
// held in the input register until the core can process it, and its
// results are registered in the result queue before they show on the
// output, one result per accepted output request; a two-bundle queue sits
// between the sequencer state and the output. Reset is synchronous and
// active low; it returns to idle with the timeout limit at 12. A stalled
// output fills the queue and the input register and then holds in_tready low.
module smbus_master_transaction_sequencer
  import smbus_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // dev_addr, read_not_write, kind, command, length, data_byte,
  // complete, arb_lost, nack, zero fill
  input  logic [39:0] in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_byte, status, zero fill
  output logic [15:0] out_tdata,
  // action
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    room;
  logic    push;
  bundle_t bnd;
  res_t    out_res;

  smbus_seq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  smbus_seq_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .room        (room),
    .take        (take),
    .push        (push),
    .bnd         (bnd)
  );

  smbus_seq_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_bnd  (bnd),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  // Pack the result fields onto the output channel.
  assign out_tdata = {5'd0, out_res.status, out_res.bus_byte};
  assign out_tuser = out_res.action;

endmodule

// ----- rtl/smbus_seq_chk.sv -----
`include "smbus_master_transaction_sequencer_defines.svh"

module smbus_seq_chk
  import smbus_seq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  logic [20:0] out_word;

  // Everything the result channel shows, in one vector.
  assign out_word = {out_tlast, out_tuser, out_tdata};

  // A stalled result keeps its value.
  `SMS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word), "result changed while stalled")

  // Done always closes the results of its request.
  `SMS_ASSERT_NOW(a_done_last, out_tvalid && (out_tuser == ACT_DONE), out_tlast, "done not last")

  // A stop is always followed by done from the same request.
  `SMS_ASSERT_NOW(a_stop_not_last, out_tvalid && (out_tuser == ACT_STOP), !out_tlast, "stop without done")

  // Status is only carried by done.
  `SMS_ASSERT_NOW(a_status_done, out_tvalid && (out_tuser != ACT_DONE), out_tdata[10:8] == ST_OK, "status outside done")

endmodule

bind smbus_master_transaction_sequencer smbus_seq_chk u_chk (.*);

// ----- tb/smbus_master_transaction_sequencer_tb.sv -----
`timescale 1ns / 1ps

module smbus_master_transaction_sequencer_tb;
  import smbus_seq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 6;

  // Predicts the bus actions of the sequencer and holds those not yet seen.
  class bus_action_tracker;
    typedef struct {
      act_t       act;
      logic [7:0] b;
      status_t    st;
      bit         last;
    } action_t;

    action_t     pending[$];
    action_t     fresh[$];
    phase_t      ph;
    logic [2:0]  xfer_kind;
    bit          rd;
    logic [6:0]  addr;
    logic [7:0]  cmd;
    int unsigned left;
    bit          first_blk;
    int unsigned waits;
    int unsigned tmo;
    int unsigned useful;
    int unsigned fails;

    function new();
      ph = PH_IDLE;
      xfer_kind = KIND_QUICK;
      rd = 1'b0;
      addr = '0;
      cmd = '0;
      left = 0;
      first_blk = 1'b0;
      waits = 0;
      tmo = 12;
      useful = 0;
      fails = 0;
    endfunction

    function void put(act_t a, logic [7:0] b, status_t s);
      action_t r;
      r.act = a;
      r.b = b;
      r.st = s;
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    function int unsigned clamp(int unsigned v);
      return (v > MAX_BLOCK) ? MAX_BLOCK : v;
    endfunction

    function void close(status_t s, bit with_stop);
      if (with_stop) put(ACT_STOP, 8'h00, ST_OK);
      put(ACT_DONE, 8'h00, s);
      ph = PH_IDLE;
      waits = 0;
    endfunction

    // Ask the host for the next write byte, or wrap up when none is left.
    function void ask_or_close();
      if (left > 0) begin
        put(ACT_NEED, 8'h00, ST_OK);
        ph = PH_NEED;
        waits = 0;
      end else begin
        close(ST_OK, 1'b1);
      end
    endfunction

    // The first byte of a block read is always acknowledged; afterwards the
    // last byte is nacked.
    function void read_or_close();
      if (first_blk) begin
        put(ACT_RDACK, 8'h00, ST_OK);
      end else if (left == 0) begin
        close(ST_OK, 1'b1);
        return;
      end else begin
        put((left > 1) ? ACT_RDACK : ACT_RDNACK, 8'h00, ST_OK);
      end
      ph = PH_RDATA;
      waits = 0;
    endfunction

    function void note_request(item_t it);
      bit acted;
      bit rbit;
      acted = 1'b1;
      fresh.delete();
      case (it.req)
        REQ_START: begin
          if (ph != PH_IDLE) begin
            acted = 1'b0;
          end else if (it.kind > KIND_I2C) begin
            put(ACT_DONE, 8'h00, ST_UNSUP);
          end else begin
            xfer_kind = it.kind;
            rd = it.read_not_write;
            addr = it.dev_addr;
            cmd = it.command;
            first_blk = 1'b0;
            case (it.kind)
              KIND_BYTE: left = rd ? 1 : 0;
              KIND_BDATA: left = 1;
              KIND_WORD: left = 2;
              KIND_BLOCK: begin
                if (rd) begin
                  left = 0;
                  first_blk = 1'b1;
                end else begin
                  left = clamp(32'(it.length));
                end
              end
              KIND_I2C: left = clamp(32'(it.length));
              default: left = 0;
            endcase
            rbit = rd && (it.kind <= KIND_BYTE);
            put(ACT_START, {addr, rbit}, ST_OK);
            ph = PH_ADDR;
            waits = 0;
          end
        end
        REQ_EVENT: begin
          if (ph == PH_IDLE || ph == PH_NEED) begin
            acted = 1'b0;
          end else if (!it.complete) begin
            close(ST_UNFINISHED, 1'b1);
          end else if (it.arb_lost) begin
            close(ST_ARB, 1'b0);
          end else if (ph != PH_RDATA && it.nack) begin
            close(ST_NOACK, 1'b1);
          end else begin
            case (ph)
              PH_ADDR: begin
                if (rd && xfer_kind <= KIND_BYTE) begin
                  read_or_close();
                end else if (xfer_kind == KIND_QUICK) begin
                  close(ST_OK, 1'b1);
                end else begin
                  put(ACT_WRITE, cmd, ST_OK);
                  ph = PH_CMD;
                  waits = 0;
                end
              end
              PH_CMD: begin
                if (rd) begin
                  put(ACT_RESTART, {addr, 1'b1}, ST_OK);
                  ph = PH_RADDR;
                  waits = 0;
                end else if (xfer_kind == KIND_BLOCK) begin
                  put(ACT_WRITE, 8'(left), ST_OK);
                  ph = PH_CNT;
                  waits = 0;
                end else begin
                  ask_or_close();
                end
              end
              PH_CNT, PH_WDATA: ask_or_close();
              PH_RADDR: read_or_close();
              PH_RDATA: begin
                put(ACT_RDATA, it.data_byte, ST_OK);
                if (first_blk) begin
                  first_blk = 1'b0;
                  left = clamp(32'(it.data_byte));
                end else if (left > 0) begin
                  left--;
                end
                read_or_close();
              end
              default: ;
            endcase
          end
        end
        REQ_WDATA: begin
          if (ph != PH_NEED) begin
            acted = 1'b0;
          end else begin
            put(ACT_WRITE, it.data_byte, ST_OK);
            if (left > 0) left--;
            ph = PH_WDATA;
            waits = 0;
          end
        end
        REQ_TICK: begin
          if (ph == PH_IDLE || ph == PH_NEED) begin
            acted = 1'b0;
          end else if (waits >= tmo) begin
            close(ST_TIMEOUT, 1'b1);
          end else begin
            waits++;
          end
        end
        default: ;
      endcase
      if (acted) useful++;
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending.push_back(fresh[i]);
    endfunction

    function void check_action(act_t a, logic [7:0] b, status_t s, logic l);
      action_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: unexpected result action %0d byte 0x%02h status %0d last %0b",
                   $time, a, b, s, l);
      end else begin
        e = pending.pop_front();
        if (e.act !== a || e.b !== b || e.st !== s || e.last !== l) begin
          fails++;
          if (fails <= 10)
            $display({"%0t: mismatch: expected action %0d byte 0x%02h status %0d last %0b,",
                      " got action %0d byte 0x%02h status %0d last %0b"},
                     $time, e.act, e.b, e.st, e.last, a, b, s, l);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = REQ_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  bus_action_tracker trk;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  smbus_master_transaction_sequencer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Cycle budget; a hang anywhere ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check accepted results and stall the output in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      trk.check_action(act_t'(out_tuser), out_tdata[7:0], status_t'(out_tdata[10:8]),
                       out_tlast);
    if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 7);
    if (!quiet && stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Builders start from random bits so that unused fields toggle too.
  function automatic item_t noise_item();
    logic [63:0] r;
    item_t it;
    r = {$urandom, $urandom};
    it = r[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic item_t start_item(logic [6:0] a, bit r, logic [2:0] k, logic [7:0] c,
                                       logic [5:0] n);
    item_t it;
    it = noise_item();
    it.req = REQ_START;
    it.dev_addr = a;
    it.read_not_write = r;
    it.kind = k;
    it.command = c;
    it.length = n;
    return it;
  endfunction

  function automatic item_t event_item(logic [7:0] b, bit c, bit al, bit nk);
    item_t it;
    it = noise_item();
    it.req = REQ_EVENT;
    it.data_byte = b;
    it.complete = c;
    it.arb_lost = al;
    it.nack = nk;
    return it;
  endfunction

  function automatic item_t data_item(logic [7:0] b);
    item_t it;
    it = noise_item();
    it.req = REQ_WDATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = noise_item();
    it.req = REQ_TICK;
    return it;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_req(item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.req;
    in_tdata <= {4'b0000, it.nack, it.arb_lost, it.complete, it.data_byte, it.length,
                 it.command, it.kind, it.read_not_write, it.dev_addr};
    do @(posedge clk); while (!in_tready);
    trk.note_request(it);
  endtask

  // Stop sending and let every predicted result come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk.tmo = 32'(v);
  endtask

  // One transaction, steered by the predicted phase, with noise and faults mixed in.
  task automatic run_transfer(int fault_pct);
    logic [2:0] k;
    logic [5:0] n;
    logic [7:0] b;
    int sel;
    k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    n = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 4));
    send_req(start_item(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), k,
                        8'($urandom_range(0, 255)), n));
    while (trk.ph != PH_IDLE) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_req(noise_item());
      end else if (trk.ph == PH_NEED) begin
        send_req(data_item(8'($urandom_range(0, 255))));
      end else if (sel < 12) begin
        send_req(tick_item());
      end else if (sel < 12 + fault_pct) begin
        case ($urandom_range(0, 3))
          0: send_req(event_item(8'($urandom_range(0, 255)), 1'b0,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          1: send_req(event_item(8'($urandom_range(0, 255)), 1'b1, 1'b1,
                                 1'($urandom_range(0, 1))));
          2: send_req(event_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1));
          default: begin
            // Let the byte wait run out; ticks do nothing while data is wanted.
            if (trk.tmo <= 40) begin
              while (trk.ph != PH_IDLE && trk.ph != PH_NEED) send_req(tick_item());
            end else begin
              send_req(event_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
            end
          end
        endcase
      end else begin
        // Block counts stay small mostly, with the odd oversized one.
        if (trk.ph == PH_RDATA && trk.first_blk && $urandom_range(0, 9) != 0)
          b = 8'($urandom_range(0, 4));
        else
          b = 8'($urandom_range(0, 255));
        send_req(event_item(b, 1'b1, 1'b0,
                            (trk.ph == PH_RDATA) ? ($urandom_range(0, 3) == 0) : 1'b0));
      end
    end
  endtask

  initial begin
    logic [15:0] settings[5];
    int unsigned goal;
    trk = new();
    settings[0] = 16'd1;
    settings[1] = 16'hFFFF;
    settings[2] = 16'd0;
    settings[3] = 16'($urandom_range(2, 30));
    settings[4] = TIMEOUT_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with the timeout limit at its reset value.
    // Quick write to the highest address.
    send_req(start_item(7'h7F, 1'b0, KIND_QUICK, 8'hFF, 6'd0));
    send_req(event_item(8'h00, 1'b1, 1'b0, 1'b0));
    // Both unsupported kinds.
    send_req(start_item(7'h00, 1'b1, 3'd6, 8'h00, 6'd0));
    send_req(start_item(7'h7F, 1'b0, 3'd7, 8'hFF, 6'h3F));
    // Byte read from address zero; a nack on the read byte is not an error.
    send_req(start_item(7'h00, 1'b1, KIND_BYTE, 8'h00, 6'd0));
    send_req(event_item(8'h00, 1'b1, 1'b0, 1'b0));
    send_req(event_item(8'hFF, 1'b1, 1'b0, 1'b1));
    // Block read whose count byte is zero.
    send_req(start_item(7'h55, 1'b1, KIND_BLOCK, 8'hA5, 6'h3F));
    repeat (3) send_req(event_item(8'hFF, 1'b1, 1'b0, 1'b0));
    send_req(event_item(8'h00, 1'b1, 1'b0, 1'b0));
    // I2C block read of length zero.
    send_req(start_item(7'h2A, 1'b1, KIND_I2C, 8'h5A, 6'd0));
    repeat (3) send_req(event_item(8'h00, 1'b1, 1'b0, 1'b0));
    // Unfinished byte, arbitration loss over a nack, and a nacked address.
    send_req(start_item(7'h01, 1'b0, KIND_BYTE, 8'h80, 6'd0));
    send_req(event_item(8'h00, 1'b0, 1'b0, 1'b0));
    send_req(start_item(7'h40, 1'b0, KIND_WORD, 8'h01, 6'd2));
    send_req(event_item(8'h00, 1'b1, 1'b1, 1'b1));
    send_req(start_item(7'h10, 1'b0, KIND_BDATA, 8'h7E, 6'd1));
    send_req(event_item(8'h00, 1'b1, 1'b0, 1'b1));
    // Requests that mean nothing while idle.
    send_req(tick_item());
    send_req(data_item(8'hC3));
    send_req(event_item(8'h3C, 1'b1, 1'b0, 1'b0));

    // Random transactions under several timeout limits; the last stretch runs
    // with no idling on either side.
    goal = trk.useful;
    foreach (settings[p]) begin
      write_timeout(settings[p]);
      if (p == 4) quiet = 1'b1;
      goal += 36;
      while (trk.useful < goal) run_transfer(10);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (trk.fails == 0 && trk.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/smbus_seq_pkg.sv
rtl/smbus_seq_in_reg.sv
rtl/smbus_seq_core.sv
rtl/smbus_seq_out_q.sv
rtl/smbus_master_transaction_sequencer.sv
rtl/smbus_seq_chk.sv
tb/smbus_master_transaction_sequencer_tb.sv
